FILE: hdl/cylinder_surface_normal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cylinder surface normal block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CYLINDER_SURFACE_NORMAL_ASSERT_SVH
`define CYLINDER_SURFACE_NORMAL_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csn assertion failed");
// next-cycle implication
`define CSN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csn assertion failed");
`else
`define CSN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/csn_pkg.sv
// ----------------------------------------------------------------------------
// csn_pkg
// Shared types and constants of the cylinder surface normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package csn_pkg;

  localparam int VEC_W     = 36;  // radial vector, signed
  localparam int SQ_STEPS  = 32;  // one root bit per stage
  localparam int DIV_STEPS = 31;  // one quotient bit per stage

  localparam logic [3:0] REG_CENTER_X = 4'd0;
  localparam logic [3:0] REG_CENTER_Y = 4'd1;
  localparam logic [3:0] REG_CENTER_Z = 4'd2;
  localparam logic [3:0] REG_AXIS_X   = 4'd3;
  localparam logic [3:0] REG_AXIS_Y   = 4'd4;
  localparam logic [3:0] REG_AXIS_Z   = 4'd5;
  localparam logic [3:0] REG_HEIGHT   = 4'd6;
  localparam logic [3:0] REG_CAP_TOL  = 4'd7;

  typedef enum logic [1:0] {
    PART_TOP    = 2'd0,
    PART_BOTTOM = 2'd1,
    PART_SIDE   = 2'd2,
    PART_DEGEN  = 2'd3
  } part_t;

  typedef enum logic {
    KIND_HIT  = 1'b0,
    KIND_AXIS = 1'b1
  } kind_t;

  typedef logic [2:0][30:0] m3_t;

  // front -> back queue entry
  typedef struct packed {
    kind_t                  kind;
    logic                   direct;  // normal already known
    part_t                  part;
    logic [2:0][VEC_W-1:0]  vec;     // vector to normalize
    logic [2:0][31:0]       dnorm;   // normal when direct
  } qitem_t;

  // side info that rides along the normalize pipeline
  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic             direct;
    part_t            part;
    logic [2:0][31:0] dnorm;
    logic [2:0]       sgn;
    logic             zero;
  } side_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    part_t            part;
    logic [2:0][31:0] n;
  } nres_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [2:0][31:0] u;
  } axis_upd_t;

endpackage

`default_nettype wire

FILE: hdl/csn_front.sv
// ----------------------------------------------------------------------------
// csn_front
// Config registers, item intake, axial projection and cap classification.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cylinder_surface_normal_assert.svh"

module csn_front import csn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_hit_x,
  input  logic signed [31:0] in_hit_y,
  input  logic signed [31:0] in_hit_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  axis_upd_t          upd,
  output logic               q_push,
  output qitem_t             q_item
);

  logic signed [31:0] center_r [3];
  logic signed [31:0] axis_r [3];
  logic [30:0]        height_r;
  logic [30:0]        tol_r;
  logic signed [31:0] u_r [3];
  logic               axis_ok_r;
  logic               dirty_r, dirty_nxt;
  logic               inflight_r, inflight_nxt;

  logic               axis_wr, inject, accept;
  logic signed [31:0] hit [3];

  logic [4:0]         v_r;
  kind_t              k_r [4];
  logic signed [32:0] oc0_r [3], oc1_r [3], oc2_r [3], oc3_r [3];
  logic signed [32:0] oc0_nxt [3];
  logic [62:0]        pr1_r [3], pr1_nxt [3];
  logic [2:0]         ng1_r, ng1_nxt;
  logic [35:0]        p2_r, p2_nxt;
  logic [65:0]        pm3_r [3], pm3_nxt [3];
  logic [2:0]         pn3_r, pn3_nxt;
  logic               dir3_r, dir3_nxt;
  part_t              part3_r, part3_nxt;
  qitem_t             q_r, q_nxt;

  logic [32:0]        oc_mag [3];
  logic [31:0]        u_mag [3];

  assign cfg_ready = 1'b1;
  assign axis_wr   = cfg_valid && ((cfg_index == REG_AXIS_X) || (cfg_index == REG_AXIS_Y) ||
                                   (cfg_index == REG_AXIS_Z));
  assign busy      = dirty_r || inflight_r || cfg_valid;
  assign accept    = start && !busy;
  assign inject    = dirty_r && !inflight_r;

  assign dirty_nxt    = (dirty_r && !inject) || axis_wr;
  assign inflight_nxt = inject || (inflight_r && !upd.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= '{32'sd0, 32'sd0, 32'sd0};
      axis_r     <= '{32'sd0, 32'sd0, 32'sd65536};
      height_r   <= 31'd65536;
      tol_r      <= 31'd66;
      u_r        <= '{32'sd0, 32'sd0, 32'sd1073741824};
      axis_ok_r  <= 1'b1;
      dirty_r    <= 1'b0;
      inflight_r <= 1'b0;
    end else begin
      dirty_r    <= dirty_nxt;
      inflight_r <= inflight_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CENTER_X: center_r[0] <= cfg_data;
          REG_CENTER_Y: center_r[1] <= cfg_data;
          REG_CENTER_Z: center_r[2] <= cfg_data;
          REG_AXIS_X:   axis_r[0]   <= cfg_data;
          REG_AXIS_Y:   axis_r[1]   <= cfg_data;
          REG_AXIS_Z:   axis_r[2]   <= cfg_data;
          REG_HEIGHT:   height_r    <= cfg_data[30:0];
          REG_CAP_TOL:  tol_r       <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (upd.valid) begin
        for (int i = 0; i < 3; i++) u_r[i] <= upd.u[i];
        axis_ok_r <= upd.ok;
      end
    end
  end

  // F0: offset from center, or the raw axis for a renormalize token
  always_comb begin
    hit[0] = in_hit_x;
    hit[1] = in_hit_y;
    hit[2] = in_hit_z;
    for (int i = 0; i < 3; i++) begin
      if (inject) oc0_nxt[i] = {axis_r[i][31], axis_r[i]};
      else        oc0_nxt[i] = {hit[i][31], hit[i]} - {center_r[i][31], center_r[i]};
    end
  end

  // magnitudes for the products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      oc_mag[i] = oc0_r[i][32] ? 33'(-oc0_r[i]) : 33'(oc0_r[i]);
      u_mag[i]  = u_r[i][31] ? 32'(-u_r[i]) : 32'(u_r[i]);
    end
  end

  // F1: |oc| * |u|
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr1_nxt[i] = oc_mag[i][31:0] * u_mag[i][30:0];
      ng1_nxt[i] = oc0_r[i][32] ^ u_r[i][31];
    end
  end

  // F2: rounded sum gives axial position p
  always_comb begin
    logic [62:0] t;
    logic [35:0] q;
    p2_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      t = pr1_r[i] + 63'd536870912;
      q = {3'b000, t[62:30]};
      p2_nxt = p2_nxt + (ng1_r[i] ? 36'(-q) : q);
    end
  end

  // F3: cap tests and |p| * |u|
  always_comb begin
    logic [36:0] dtop, dbot, mtop, mbot, tol2;
    logic [35:0] pmag;
    dtop = {p2_r[35], p2_r} + {p2_r[35], p2_r} - {6'b0, height_r};
    dbot = {p2_r[35], p2_r} + {p2_r[35], p2_r} + {6'b0, height_r};
    mtop = dtop[36] ? 37'(-dtop) : dtop;
    mbot = dbot[36] ? 37'(-dbot) : dbot;
    tol2 = {5'b0, tol_r, 1'b0};
    pmag = p2_r[35] ? 36'(-p2_r) : p2_r;
    for (int i = 0; i < 3; i++) begin
      pm3_nxt[i] = pmag[34:0] * u_mag[i][30:0];
      pn3_nxt[i] = p2_r[35] ^ u_r[i][31];
    end
    if (k_r[2] == KIND_AXIS) begin
      dir3_nxt  = 1'b0;
      part3_nxt = PART_SIDE;
    end else if (!axis_ok_r) begin
      dir3_nxt  = 1'b1;
      part3_nxt = PART_DEGEN;
    end else if (mtop < tol2) begin
      dir3_nxt  = 1'b1;
      part3_nxt = PART_TOP;
    end else if (mbot < tol2) begin
      dir3_nxt  = 1'b1;
      part3_nxt = PART_BOTTOM;
    end else begin
      dir3_nxt  = 1'b0;
      part3_nxt = PART_SIDE;
    end
  end

  // F4: radial vector, queue entry
  always_comb begin
    logic [65:0] t;
    logic [35:0] rnd;
    q_nxt.kind   = k_r[3];
    q_nxt.direct = dir3_r;
    q_nxt.part   = part3_r;
    for (int i = 0; i < 3; i++) begin
      t   = pm3_r[i] + 66'd536870912;
      rnd = t[65:30];
      if (k_r[3] == KIND_AXIS) q_nxt.vec[i] = {{3{oc3_r[i][32]}}, oc3_r[i]};
      else q_nxt.vec[i] = {{3{oc3_r[i][32]}}, oc3_r[i]} - (pn3_r[i] ? 36'(-rnd) : rnd);
      case (part3_r)
        PART_TOP:    q_nxt.dnorm[i] = u_r[i];
        PART_BOTTOM: q_nxt.dnorm[i] = 32'(-u_r[i]);
        default:     q_nxt.dnorm[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], accept || inject};
    end
  end

  always_ff @(posedge clk) begin
    k_r[0]  <= inject ? KIND_AXIS : KIND_HIT;
    for (int s = 1; s < 4; s++) k_r[s] <= k_r[s-1];
    oc0_r   <= oc0_nxt;
    oc1_r   <= oc0_r;
    oc2_r   <= oc1_r;
    oc3_r   <= oc2_r;
    pr1_r   <= pr1_nxt;
    ng1_r   <= ng1_nxt;
    p2_r    <= p2_nxt;
    pm3_r   <= pm3_nxt;
    pn3_r   <= pn3_nxt;
    dir3_r  <= dir3_nxt;
    part3_r <= part3_nxt;
    q_r     <= q_nxt;
  end

  assign q_push = v_r[4];
  assign q_item = q_r;

  `CSN_ASSERT_IMP(a_upd_expected, clk, rst_n, upd.valid, inflight_r)
  `CSN_ASSERT_IMP(a_no_hit_while_dirty, clk, rst_n, accept, !inject)

endmodule

`default_nettype wire

FILE: hdl/csn_queue.sv
// ----------------------------------------------------------------------------
// csn_queue
// Two-entry queue between front and back; back drains it every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cylinder_surface_normal_assert.svh"

module csn_queue import csn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t din,
  output logic   valid,
  output qitem_t dout
);

  qitem_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop     = (cnt_r != 2'd0);
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  assign valid   = pop;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  `CSN_ASSERT_IMP(a_no_overflow, clk, rst_n, push && (cnt_r == 2'd2), pop)
  `CSN_ASSERT_NXT(a_drains, clk, rst_n, !push, cnt_r != 2'd2)

endmodule

`default_nettype wire

FILE: hdl/csn_norm.sv
// ----------------------------------------------------------------------------
// csn_norm
// Pipelined vector normalize: scale, sum of squares, root, divide.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cylinder_surface_normal_assert.svh"

module csn_norm import csn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  qitem_t din,
  output nres_t  res
);

  // A: magnitudes
  side_t              a_side_r, a_side_nxt;
  logic [2:0][35:0]   a_mag_r, a_mag_nxt;
  // B: leading one of the largest
  side_t              b_side_r, b_side_nxt;
  logic [2:0][35:0]   b_mag_r;
  logic [5:0]         b_k_r, b_k_nxt;
  // C: scaled to [2^30, 2^31)
  side_t              c_side_r;
  m3_t                c_m_r, c_m_nxt;
  // D: squares
  side_t              d_side_r;
  m3_t                d_m_r;
  logic [2:0][61:0]   d_sq_r, d_sq_nxt;
  // E: sum
  side_t              e_side_r;
  m3_t                e_m_r;
  logic [63:0]        e_s_r, e_s_nxt;
  // root stages
  logic [32:0]        sr_rem_r [SQ_STEPS], sr_rem_in [SQ_STEPS], sr_rem_nxt [SQ_STEPS];
  logic [31:0]        sr_root_r [SQ_STEPS], sr_root_in [SQ_STEPS], sr_root_nxt [SQ_STEPS];
  logic [63:0]        sr_s_r [SQ_STEPS], sr_s_in [SQ_STEPS], sr_s_nxt [SQ_STEPS];
  m3_t                sr_m_r [SQ_STEPS], sr_m_in [SQ_STEPS];
  side_t              sr_side_r [SQ_STEPS], sr_side_in [SQ_STEPS];
  // divide setup
  side_t              f_side_r;
  logic [31:0]        f_len_r;
  logic [2:0][32:0]   f_rem_r, f_rem_nxt;
  logic [2:0][30:0]   f_low_r, f_low_nxt;
  // divide stages
  logic [2:0][32:0]   dv_rem_r [DIV_STEPS], dv_rem_in [DIV_STEPS], dv_rem_nxt [DIV_STEPS];
  logic [2:0][30:0]   dv_low_r [DIV_STEPS], dv_low_in [DIV_STEPS], dv_low_nxt [DIV_STEPS];
  logic [2:0][30:0]   dv_q_r [DIV_STEPS], dv_q_in [DIV_STEPS], dv_q_nxt [DIV_STEPS];
  logic [31:0]        dv_len_r [DIV_STEPS], dv_len_in [DIV_STEPS];
  side_t              dv_side_r [DIV_STEPS], dv_side_in [DIV_STEPS];
  // result
  nres_t              res_r, res_nxt;
  logic               n_in_range;

  always_comb begin
    a_side_nxt.valid  = in_valid;
    a_side_nxt.kind   = din.kind;
    a_side_nxt.direct = din.direct;
    a_side_nxt.part   = din.part;
    a_side_nxt.dnorm  = din.dnorm;
    a_side_nxt.zero   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a_side_nxt.sgn[i] = din.vec[i][VEC_W-1];
      a_mag_nxt[i] = din.vec[i][VEC_W-1] ? 36'(-din.vec[i]) : din.vec[i];
    end
  end

  always_comb begin
    logic [35:0] mx;
    mx = a_mag_r[0];
    if (a_mag_r[1] > mx) mx = a_mag_r[1];
    if (a_mag_r[2] > mx) mx = a_mag_r[2];
    b_k_nxt = '0;
    for (int b = 0; b < 36; b++) begin
      if (mx[b]) b_k_nxt = 6'(b);
    end
    b_side_nxt      = a_side_r;
    b_side_nxt.zero = (mx == '0);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_k_r >= 6'd30) c_m_nxt[i] = 31'(b_mag_r[i] >> (b_k_r - 6'd30));
      else                c_m_nxt[i] = 31'(b_mag_r[i] << (6'd30 - b_k_r));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) d_sq_nxt[i] = c_m_r[i] * c_m_r[i];
  end

  assign e_s_nxt = {2'b00, d_sq_r[0]} + {2'b00, d_sq_r[1]} + {2'b00, d_sq_r[2]};

  // integer square root, two radicand bits per stage
  always_comb begin
    logic [34:0] r4, trial;
    sr_rem_in[0]  = '0;
    sr_root_in[0] = '0;
    sr_s_in[0]    = e_s_r;
    sr_m_in[0]    = e_m_r;
    sr_side_in[0] = e_side_r;
    for (int j = 1; j < SQ_STEPS; j++) begin
      sr_rem_in[j]  = sr_rem_r[j-1];
      sr_root_in[j] = sr_root_r[j-1];
      sr_s_in[j]    = sr_s_r[j-1];
      sr_m_in[j]    = sr_m_r[j-1];
      sr_side_in[j] = sr_side_r[j-1];
    end
    for (int j = 0; j < SQ_STEPS; j++) begin
      r4    = {sr_rem_in[j], sr_s_in[j][63:62]};
      trial = {1'b0, sr_root_in[j], 2'b01};
      if (r4 >= trial) begin
        sr_rem_nxt[j]  = 33'(r4 - trial);
        sr_root_nxt[j] = {sr_root_in[j][30:0], 1'b1};
      end else begin
        sr_rem_nxt[j]  = r4[32:0];
        sr_root_nxt[j] = {sr_root_in[j][30:0], 1'b0};
      end
      sr_s_nxt[j] = {sr_s_in[j][61:0], 2'b00};
    end
  end

  // dividend m * 2^30 + len / 2, first 31 bits preloaded
  always_comb begin
    logic [61:0] num;
    for (int i = 0; i < 3; i++) begin
      num = {1'b0, sr_m_r[SQ_STEPS-1][i], 30'b0} +
            {31'b0, sr_root_r[SQ_STEPS-1][31:1]};
      f_rem_nxt[i] = {2'b00, num[61:31]};
      f_low_nxt[i] = num[30:0];
    end
  end

  // restoring divide, one quotient bit per stage
  always_comb begin
    logic [33:0] t;
    dv_rem_in[0]  = f_rem_r;
    dv_low_in[0]  = f_low_r;
    dv_q_in[0]    = '0;
    dv_len_in[0]  = f_len_r;
    dv_side_in[0] = f_side_r;
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_rem_in[j]  = dv_rem_r[j-1];
      dv_low_in[j]  = dv_low_r[j-1];
      dv_q_in[j]    = dv_q_r[j-1];
      dv_len_in[j]  = dv_len_r[j-1];
      dv_side_in[j] = dv_side_r[j-1];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        t = {dv_rem_in[j][i], dv_low_in[j][i][30]};
        if (t >= {2'b00, dv_len_in[j]}) begin
          dv_rem_nxt[j][i] = 33'(t - {2'b00, dv_len_in[j]});
          dv_q_nxt[j][i]   = {dv_q_in[j][i][29:0], 1'b1};
        end else begin
          dv_rem_nxt[j][i] = t[32:0];
          dv_q_nxt[j][i]   = {dv_q_in[j][i][29:0], 1'b0};
        end
        dv_low_nxt[j][i] = {dv_low_in[j][i][29:0], 1'b0};
      end
    end
  end

  always_comb begin
    side_t s;
    s             = dv_side_r[DIV_STEPS-1];
    res_nxt.valid = s.valid;
    res_nxt.kind  = s.kind;
    if (s.direct)    res_nxt.part = s.part;
    else if (s.zero) res_nxt.part = PART_DEGEN;
    else             res_nxt.part = PART_SIDE;
    for (int i = 0; i < 3; i++) begin
      if (s.direct)      res_nxt.n[i] = s.dnorm[i];
      else if (s.zero)   res_nxt.n[i] = '0;
      else if (s.sgn[i]) res_nxt.n[i] = 32'(-{1'b0, dv_q_r[DIV_STEPS-1][i]});
      else               res_nxt.n[i] = {1'b0, dv_q_r[DIV_STEPS-1][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r.valid <= 1'b0;
      b_side_r.valid <= 1'b0;
      c_side_r.valid <= 1'b0;
      d_side_r.valid <= 1'b0;
      e_side_r.valid <= 1'b0;
      f_side_r.valid <= 1'b0;
      for (int j = 0; j < SQ_STEPS; j++)  sr_side_r[j].valid <= 1'b0;
      for (int j = 0; j < DIV_STEPS; j++) dv_side_r[j].valid <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      a_side_r  <= a_side_nxt;
      b_side_r  <= b_side_nxt;
      c_side_r  <= b_side_r;
      d_side_r  <= c_side_r;
      e_side_r  <= d_side_r;
      sr_side_r <= sr_side_in;
      f_side_r  <= sr_side_r[SQ_STEPS-1];
      dv_side_r <= dv_side_in;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_mag_r    <= a_mag_nxt;
    b_mag_r    <= a_mag_r;
    b_k_r      <= b_k_nxt;
    c_m_r      <= c_m_nxt;
    d_m_r      <= c_m_r;
    d_sq_r     <= d_sq_nxt;
    e_m_r      <= d_m_r;
    e_s_r      <= e_s_nxt;
    sr_rem_r   <= sr_rem_nxt;
    sr_root_r  <= sr_root_nxt;
    sr_s_r     <= sr_s_nxt;
    sr_m_r     <= sr_m_in;
    f_len_r    <= sr_root_r[SQ_STEPS-1];
    f_rem_r    <= f_rem_nxt;
    f_low_r    <= f_low_nxt;
    dv_rem_r   <= dv_rem_nxt;
    dv_low_r   <= dv_low_nxt;
    dv_q_r     <= dv_q_nxt;
    dv_len_r   <= dv_len_in;
  end

  assign res = res_r;

  // a unit normal never exceeds one in any component
  always_comb begin
    n_in_range = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (($signed(res_r.n[i]) > 32'sd1073741824) ||
          ($signed(res_r.n[i]) < -32'sd1073741824)) n_in_range = 1'b0;
    end
  end

  `CSN_ASSERT_IMP(a_unit_range, clk, rst_n, res_r.valid, n_in_range)

endmodule

`default_nettype wire

FILE: hdl/cylinder_surface_normal.sv
// ----------------------------------------------------------------------------
// cylinder_surface_normal
// Unit surface normal of a configured capped cylinder at a hit point.
// ----------------------------------------------------------------------------
//
//   channel  ports                               handshake
//   -------  ----------------------------------  -------------------------
//   input    start, busy, in_hit_x/y/z           taken when start && !busy
//   result   out_strobe, out_normal_x/y/z,       one cycle per item,
//            out_surface_part                    no back pressure
//   config   cfg_valid, cfg_ready, cfg_index,    write when valid && ready
//            cfg_data
//
// One item per cycle while busy is low. The back end's normalize pipeline
// has 32 square-root stages, one root bit each, followed by 31 divide
// stages, one quotient bit each. A write to any axis register relaunches
// the axis normalize through the same pipeline; busy stays high until the
// new unit axis is back. busy is also high while cfg_valid is offered.
// Synchronous active-low reset; the reset axis is already in unit form,
// so no start-up pass is needed. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module cylinder_surface_normal import csn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // item intake
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_hit_x,
  input  logic signed [31:0] in_hit_y,
  input  logic signed [31:0] in_hit_z,
  // results
  output logic               out_strobe,
  output logic signed [31:0] out_normal_x,
  output logic signed [31:0] out_normal_y,
  output logic signed [31:0] out_normal_z,
  output logic [1:0]         out_surface_part,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  qitem_t    f_item, q_item;
  logic      f_push, q_valid;
  nres_t     nres;
  axis_upd_t upd;

  // Front: register file, offset from center, axial projection p,
  // cap tests and the radial vector. Cap hits are resolved here and
  // ride the back end untouched so results stay in order.
  csn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_hit_x  (in_hit_x),
    .in_hit_y  (in_hit_y),
    .in_hit_z  (in_hit_z),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd       (upd),
    .q_push    (f_push),
    .q_item    (f_item)
  );

  csn_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .valid (q_valid),
    .dout  (q_item)
  );

  // Back: shared normalize pipeline for radial vectors and the axis.
  csn_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (q_valid),
    .din      (q_item),
    .res      (nres)
  );

  // hit items go out; axis tokens update the front's unit axis
  assign out_strobe       = nres.valid && (nres.kind == KIND_HIT);
  assign out_normal_x     = nres.n[0];
  assign out_normal_y     = nres.n[1];
  assign out_normal_z     = nres.n[2];
  assign out_surface_part = nres.part;

  assign upd.valid = nres.valid && (nres.kind == KIND_AXIS);
  assign upd.ok    = (nres.part != PART_DEGEN);
  assign upd.u     = nres.n;

endmodule

`default_nettype wire

FILE: test/cylinder_surface_normal_tb.sv
// ----------------------------------------------------------------------------
// cylinder_surface_normal_tb
// Self-checking bench: feeds hit points, predicts each normal in fixed point or
// takes it from the table, and compares every strobed result against the oldest pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cylinder_surface_normal_tb;
  import csn_pkg::*;

  localparam logic [3:0] REG_UNUSED = 4'd12;  // outside the register map
  localparam int SETTLE_CYCLES = 120;         // covers the pipeline latency
  localparam longint HALF_LSB = 64'sd1 << 29;

  typedef struct {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    part_t       part;
  } normal_rec_t;

  typedef struct {
    int          x;
    int          y;
    int          z;
    bit          typed;  // expected value written in the table
    normal_rec_t want;
  } hit_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_hit_x = '0, in_hit_y = '0, in_hit_z = '0;
  logic out_strobe;
  logic signed [31:0] out_normal_x, out_normal_y, out_normal_z;
  logic [1:0] out_surface_part;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] cyl_regs [8];       // shadow of the block's registers
  normal_rec_t pending_normals[$];
  int errors = 0;
  int idle_pct = 0;

  always #10 clk = ~clk;

  cylinder_surface_normal uut (.*);

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned isqrt_u64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_u(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  // Q16.16 * Q2.30 -> Q16.16, half away from zero
  function automatic longint mul_q30(longint a, longint b);
    longint unsigned m;
    m = (abs_u(a) * abs_u(b) + HALF_LSB) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // unit vector in Q2.30; returns 0 for the zero vector
  function automatic bit unit_vec(input longint v0, v1, v2,
                                  output longint u0, u1, u2);
    longint unsigned m [3];
    longint unsigned mx, s, len;
    longint v [3];
    longint u [3];
    v[0] = v0; v[1] = v1; v[2] = v2;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs_u(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    u0 = 0; u1 = 0; u2 = 0;
    if (mx == 0) return 1'b0;
    // bring the largest magnitude into [2^30, 2^31)
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    len = isqrt_u64(s);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(((m[i] << 30) + (len >> 1)) / len);
      if (v[i] < 0) u[i] = -u[i];
    end
    u0 = u[0]; u1 = u[1]; u2 = u[2];
    return 1'b1;
  endfunction

  function automatic longint reg_s(int idx);
    return longint'($signed(cyl_regs[idx]));
  endfunction

  function automatic normal_rec_t predict_normal(int hx, int hy, int hz);
    normal_rec_t rec;
    longint oc [3];
    longint u [3];
    longint n [3];
    longint p, h, tol2, dtop, dbot;
    oc[0] = longint'(hx) - reg_s(REG_CENTER_X);
    oc[1] = longint'(hy) - reg_s(REG_CENTER_Y);
    oc[2] = longint'(hz) - reg_s(REG_CENTER_Z);
    h = longint'({33'd0, cyl_regs[REG_HEIGHT][30:0]});
    tol2 = 2 * longint'({33'd0, cyl_regs[REG_CAP_TOL][30:0]});
    n[0] = 0; n[1] = 0; n[2] = 0;
    rec.part = PART_DEGEN;
    if (unit_vec(reg_s(REG_AXIS_X), reg_s(REG_AXIS_Y), reg_s(REG_AXIS_Z),
                 u[0], u[1], u[2])) begin
      p = mul_q30(oc[0], u[0]) + mul_q30(oc[1], u[1]) + mul_q30(oc[2], u[2]);
      dtop = 2 * p - h;
      dbot = 2 * p + h;
      if (longint'(abs_u(dtop)) < tol2) begin
        n = u;
        rec.part = PART_TOP;
      end else if (longint'(abs_u(dbot)) < tol2) begin
        for (int i = 0; i < 3; i++) n[i] = -u[i];
        rec.part = PART_BOTTOM;
      end else if (unit_vec(oc[0] - mul_q30(p, u[0]), oc[1] - mul_q30(p, u[1]),
                            oc[2] - mul_q30(p, u[2]), n[0], n[1], n[2])) begin
        rec.part = PART_SIDE;
      end
    end
    rec.nx = n[0][31:0];
    rec.ny = n[1][31:0];
    rec.nz = n[2][31:0];
    return rec;
  endfunction

  // ------------------------------------------------------------- result check
  // results cannot be held off: sample every strobe at the edge ending it
  always @(posedge clk) begin
    normal_rec_t exp_n;
    if (rst_n && out_strobe) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected normal %0d %0d %0d part %0d", $time,
                 out_normal_x, out_normal_y, out_normal_z, out_surface_part);
        errors++;
      end else begin
        exp_n = pending_normals.pop_front();
        if (out_normal_x !== exp_n.nx) begin
          $display("%0t: normal_x exp %0d act %0d", $time,
                   $signed(exp_n.nx), out_normal_x);
          errors++;
        end
        if (out_normal_y !== exp_n.ny) begin
          $display("%0t: normal_y exp %0d act %0d", $time,
                   $signed(exp_n.ny), out_normal_y);
          errors++;
        end
        if (out_normal_z !== exp_n.nz) begin
          $display("%0t: normal_z exp %0d act %0d", $time,
                   $signed(exp_n.nz), out_normal_z);
          errors++;
        end
        if (out_surface_part !== exp_n.part) begin
          $display("%0t: surface_part exp %0d act %0d", $time,
                   exp_n.part, out_surface_part);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------ drivers
  // start stays high across back-to-back items; it drops only for an idle gap or a drain
  task automatic send_hit(int hx, int hy, int hz, bit typed, normal_rec_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_hit_x <= hx;
    in_hit_y <= hy;
    in_hit_z <= hz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_normals.push_back(typed ? want : predict_normal(hx, hy, hz));
  endtask

  // registers change only once the pipe has fully drained
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid drops after each write, so it is low between writes
  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_CAP_TOL)
      cyl_regs[idx] = (idx >= REG_HEIGHT) ? {1'b0, val[30:0]} : val;
    @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] cx, cy, cz, ax, ay, az, ht, tol);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_AXIS_X, ax);
    write_reg(REG_AXIS_Y, ay);
    write_reg(REG_AXIS_Z, az);
    write_reg(REG_HEIGHT, ht);
    write_reg(REG_CAP_TOL, tol);
  endtask

  function automatic int rnd_signed();
    return int'($urandom) >>> $urandom_range(31);
  endfunction

  task automatic random_config();
    logic [31:0] ax, ay, az;
    ax = rnd_signed();
    ay = rnd_signed();
    az = rnd_signed();
    if ($urandom_range(19) == 0) begin  // zero axis now and then
      ax = '0; ay = '0; az = '0;
    end
    write_all(rnd_signed() >>> $urandom_range(8), rnd_signed() >>> $urandom_range(8),
              rnd_signed() >>> $urandom_range(8), ax, ay, az,
              $urandom >> $urandom_range(1, 31), $urandom >> $urandom_range(8, 31));
  endtask

  // mostly points near one of the caps, some on the axis, the rest wide random points
  task automatic random_hits(int count);
    normal_rec_t none;
    longint u [3];
    longint half, off, tol;
    int sel;
    void'(unit_vec(reg_s(REG_AXIS_X), reg_s(REG_AXIS_Y), reg_s(REG_AXIS_Z),
                   u[0], u[1], u[2]));
    tol = longint'({33'd0, cyl_regs[REG_CAP_TOL][30:0]});
    half = longint'({33'd0, cyl_regs[REG_HEIGHT][30:0]}) / 2;
    none = '{nx: '0, ny: '0, nz: '0, part: PART_TOP};
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(9);
      if (sel < 7) begin
        off = (sel < 4) ? half : -half;
        off += longint'(rnd_signed()) % (tol + 1);
        send_hit(int'(reg_s(REG_CENTER_X) + mul_q30(off, u[0]) + (rnd_signed() >>> 12)),
                 int'(reg_s(REG_CENTER_Y) + mul_q30(off, u[1]) + (rnd_signed() >>> 12)),
                 int'(reg_s(REG_CENTER_Z) + mul_q30(off, u[2]) + (rnd_signed() >>> 12)),
                 1'b0, none);
      end else if (sel == 7) begin
        // on the axis itself: radial vector rounds to zero
        off = rnd_signed() >>> 8;
        send_hit(int'(reg_s(REG_CENTER_X) + mul_q30(off, u[0])),
                 int'(reg_s(REG_CENTER_Y) + mul_q30(off, u[1])),
                 int'(reg_s(REG_CENTER_Z) + mul_q30(off, u[2])), 1'b0, none);
      end else begin
        send_hit(int'($urandom), int'($urandom), int'($urandom), 1'b0, none);
      end
    end
  endtask

  // ------------------------------------------------------------ main sequence
  hit_row_t dir_rows [$];

  function automatic hit_row_t mk_row(int x, y, z, bit typed, int nx, ny, nz,
                                      part_t part);
    hit_row_t r;
    r.x = x; r.y = y; r.z = z; r.typed = typed;
    r.want.nx = nx; r.want.ny = ny; r.want.nz = nz; r.want.part = part;
    return r;
  endfunction

  initial begin
    normal_rec_t none;
    none = '{nx: '0, ny: '0, nz: '0, part: PART_TOP};
    for (int i = 0; i < 8; i++) cyl_regs[i] = '0;
    cyl_regs[REG_AXIS_Z] = 32'd65536;
    cyl_regs[REG_HEIGHT] = 32'd65536;
    cyl_regs[REG_CAP_TOL] = 32'd66;

    // reset cylinder: unit z axis, height 1.0, caps at z = +-0.5
    dir_rows.push_back(mk_row(0, 0, 32768, 1, 0, 0, 1 << 30, PART_TOP));
    dir_rows.push_back(mk_row(0, 0, -32768, 1, 0, 0, -(1 << 30), PART_BOTTOM));
    dir_rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 0, PART_DEGEN));
    dir_rows.push_back(mk_row(65536, 0, 0, 1, 1 << 30, 0, 0, PART_SIDE));
    dir_rows.push_back(mk_row(0, -65536, 0, 1, 0, -(1 << 30), 0, PART_SIDE));
    dir_rows.push_back(mk_row(0, 0, 32768 + 65, 1, 0, 0, 1 << 30, PART_TOP));
    dir_rows.push_back(mk_row(0, 0, 32768 + 66, 1, 0, 0, 0, PART_DEGEN));
    dir_rows.push_back(mk_row(100, 0, 40000, 0, 0, 0, 0, PART_SIDE));
    dir_rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
                              0, 0, 0, PART_SIDE));
    dir_rows.push_back(mk_row(32'h80000000, 32'h80000000, 32'h80000000, 0,
                              0, 0, 0, PART_SIDE));
    dir_rows.push_back(mk_row(32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, PART_SIDE));
    dir_rows.push_back(mk_row(-1, 1, -1, 0, 0, 0, 0, PART_SIDE));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_hit(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
               dir_rows[i].want);
    drain();

    // zero axis: every point is degenerate; stray index must be ignored
    write_reg(REG_AXIS_Z, 32'd0);
    write_reg(REG_UNUSED, 32'hffffffff);
    send_hit(0, 0, 0, 1, '{0, 0, 0, PART_DEGEN});
    send_hit(12345, -999, 32'h7fffffff, 1, '{0, 0, 0, PART_DEGEN});
    drain();

    // register extremes
    write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h00000001, 32'h7fffffff, 32'h7fffffff);
    send_hit(0, 0, 0, 0, none);
    send_hit(32'h80000000, 32'h7fffffff, 32'h80000000, 0, none);
    send_hit(32'h7fffffff, 32'h80000000, 0, 0, none);
    drain();
    write_all(32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
              32'h80000000, 0, 0);
    send_hit(32'h80000000, 0, 32'h7fffffff, 0, none);
    send_hit(0, 65536, -65536, 0, none);
    send_hit(32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, none);
    drain();

    // random part: three idle profiles, fresh cylinder every 110 items
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 10 : (ph == 1) ? 73 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        random_config();
        random_hits(110);
        drain();
      end
    end

    if (errors == 0)
      $display("cylinder_surface_normal regression: pass");
    else
      $display("cylinder_surface_normal regression: fail");
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("cylinder_surface_normal regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/csn_pkg.sv
hdl/csn_front.sv
hdl/csn_queue.sv
hdl/csn_norm.sv
hdl/cylinder_surface_normal.sv
test/cylinder_surface_normal_tb.sv
